// File: rtl/core/rqpm_pkg.sv
// Shared types and constants of the ready queue priority merge block.
package rqpm_pkg;

  // Default depth of the ready list.
  localparam int MaxTasksDef = 32;

  // One pending task beat.
  typedef struct packed {
    logic [7:0] task_id;
    logic [7:0] task_priority;
    logic       last_pending;
  } rqpm_in_t;

  // Result codes of one merge.
  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StListFull  = 2'd1,
    StPrioZero  = 2'd2
  } rqpm_status_e;

  // One result beat.
  typedef struct packed {
    logic         head_changed;
    logic [7:0]   running_task;
    logic [4:0]   insert_position;
    logic         switch_needed;
    rqpm_status_e status;
  } rqpm_out_t;

  // One ready list entry as held in a cell.
  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] id;
  } rqpm_entry_t;

endpackage

// File: rtl/core/rqpm_cell.sv
// One cell of the sorted ready list: holds an entry, keeps it, takes the new task or shifts.
module rqpm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  rqpm_pkg::rqpm_entry_t item_i,
  input  rqpm_pkg::rqpm_entry_t prev_i,
  input  logic                prev_keep_i,
  output rqpm_pkg::rqpm_entry_t entry_o,
  output logic                keep_o,
  output logic                place_o
);
  import rqpm_pkg::*;

  rqpm_entry_t entry_q, entry_d;

  // An entry of equal or higher priority stays ahead of the new task.
  // Empty cells hold the idle priority 0, so they never stay.
  assign keep_o  = (entry_q.prio >= item_i.prio);
  assign place_o = prev_keep_i && !keep_o;
  assign entry_o = entry_q;

  // Keep, take the new task at the insert point, or take the neighbor's entry.
  always_comb begin
    entry_d = entry_q;
    if (en_i && !keep_o) begin
      if (prev_keep_i) begin
        entry_d = item_i;
      end else begin
        entry_d = prev_i;
      end
    end
  end

  // Every cell starts as the idle task, id 0 at priority 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

// File: rtl/core/ready_queue_priority_merge_top.sv
// Top level of the ready queue priority merge block: item register, cell chain, result register.
//
// Each pending task beat is held in an item register and merged into a row of MAX_TASKS
// cells once the result register is free or being emptied: every cell compares its priority
// with the new task at once and either keeps its entry, takes the new task, or takes its
// neighbor's entry. Each result beat is held in a result register, and the block takes
// one input beat per cycle as long as results are taken. The list starts with the idle
// task alone; a priority of zero or a full list drops the task with a status code.
module ready_queue_priority_merge_top #(
  parameter int MAX_TASKS = rqpm_pkg::MaxTasksDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rqpm_pkg::rqpm_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rqpm_pkg::rqpm_out_t out_data_o
);
  import rqpm_pkg::*;

  localparam int IdxW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CntW    = $clog2(MAX_TASKS + 1);
  localparam int PosExtW = IdxW + 5;

  rqpm_in_t    item_q;
  logic        busy_q;
  logic        out_valid_q;
  rqpm_out_t   out_q, out_d;
  logic [CntW-1:0] count_q, count_d;
  logic        batch_q, batch_d;

  logic        exec;
  logic        do_insert;
  rqpm_status_e status;
  rqpm_entry_t item_entry;

  rqpm_entry_t entries [MAX_TASKS];
  logic [MAX_TASKS-1:0] keep;
  logic [MAX_TASKS-1:0] place;

  logic [IdxW-1:0]    pos;
  logic [PosExtW-1:0] pos_ext;
  logic               took_head;

  // The item register moves on when the result register is free or being emptied.
  assign exec       = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || exec;

  assign item_entry.prio = item_q.task_priority;
  assign item_entry.id   = item_q.task_id;

  // Priority zero is checked before the full list.
  always_comb begin
    if (item_q.task_priority == 8'd0) begin
      status = StPrioZero;
    end else if (count_q == CntW'(MAX_TASKS)) begin
      status = StListFull;
    end else begin
      status = StInserted;
    end
  end
  assign do_insert = exec && (status == StInserted);

  // Chain of cells, the head at index 0.
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    rqpm_entry_t prev;
    logic        prev_keep;
    if (g == 0) begin : g_head
      assign prev      = '0;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev      = entries[g-1];
      assign prev_keep = keep[g-1];
    end
    rqpm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (do_insert),
      .item_i      (item_entry),
      .prev_i      (prev),
      .prev_keep_i (prev_keep),
      .entry_o     (entries[g]),
      .keep_o      (keep[g]),
      .place_o     (place[g])
    );
  end

  // Encode the one-hot insert point into an index.
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (place[i]) begin
        pos = pos | IdxW'(i);
      end
    end
  end
  assign pos_ext   = PosExtW'(pos);
  assign took_head = (status == StInserted) && place[0];

  // Result beat, list count and batch flag.
  always_comb begin
    out_d.head_changed    = took_head;
    out_d.running_task    = took_head ? item_q.task_id : entries[0].id;
    out_d.insert_position = (status == StInserted) ? pos_ext[4:0] : 5'd0;
    out_d.switch_needed   = item_q.last_pending && (batch_q || took_head);
    out_d.status          = status;
    count_d = count_q;
    batch_d = batch_q;
    if (exec) begin
      if (status == StInserted) begin
        count_d = count_q + CntW'(1);
      end
      batch_d = item_q.last_pending ? 1'b0 : (batch_q || took_head);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= CntW'(1);
      batch_q     <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      count_q <= count_d;
      batch_q <= batch_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (exec) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/ready_queue_priority_merge_top_tb.sv
// Self-checking testbench of the ready queue priority merge block.
`timescale 1ns / 100ps

module ready_queue_priority_merge_top_tb;
  import rqpm_pkg::*;

  localparam int MaxTasks     = MaxTasksDef;
  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 7;
  localparam int PhaseItems   = 460;
  localparam int RxHoldCycles = 300;
  localparam int DrainCycles  = 8;
  localparam int CycleLimit   = 400000;
  localparam int MaxReports   = 10;

  // One row of the directed table; the result is typed in only where obvious.
  typedef struct {
    rqpm_in_t  beat;
    bit        typed;
    rqpm_out_t result;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  rqpm_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  rqpm_out_t out_data_o;

  // Predicted ready list and batch flag.
  logic [7:0] sched_prio [MaxTasks];
  logic [7:0] sched_id [MaxTasks];
  int         sched_len;
  bit         sched_switch;

  rqpm_out_t sched_result_q[$];
  dir_row_t  dir_rows[$];
  int        mismatch_count;
  int        cycle_count;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        rx_hold_requests;
  int        rx_hold_served;
  int        rx_hold_left;

  ready_queue_priority_merge_top #(
    .MAX_TASKS(MaxTasks)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clock generation.
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Cycle counter for the run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Merge one pending task into the predicted list and return its result beat.
  function automatic rqpm_out_t predict_merge(input rqpm_in_t beat);
    rqpm_out_t r;
    int        slot;
    int        k;
    r.head_changed    = 1'b0;
    r.insert_position = '0;
    r.switch_needed   = 1'b0;
    r.status          = StInserted;
    if (beat.task_priority == 8'd0) begin
      r.status = StPrioZero;
    end else if (sched_len >= MaxTasks) begin
      r.status = StListFull;
    end else begin
      // Equal priorities keep arrival order, so skip past them.
      slot = 0;
      while (slot < sched_len && sched_prio[slot] >= beat.task_priority) slot++;
      for (k = sched_len; k > slot; k--) begin
        sched_prio[k] = sched_prio[k-1];
        sched_id[k]   = sched_id[k-1];
      end
      sched_prio[slot] = beat.task_priority;
      sched_id[slot]   = beat.task_id;
      sched_len++;
      r.insert_position = slot[4:0];
      if (slot == 0) begin
        r.head_changed = 1'b1;
        sched_switch   = 1'b1;
      end
    end
    if (beat.last_pending) begin
      r.switch_needed = sched_switch;
      sched_switch    = 1'b0;
    end
    r.running_task = sched_id[0];
    return r;
  endfunction

  // Offer one beat after a random gap and record its expected result on acceptance.
  task automatic offer_task(input rqpm_in_t beat, input bit typed, input rqpm_out_t typed_res);
    rqpm_out_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_merge(beat);
    sched_result_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic add_row(input logic [7:0] id, input logic [7:0] prio, input bit last,
                         input bit typed, input bit hc, input logic [7:0] run,
                         input logic [4:0] pos, input bit sw, input rqpm_status_e st);
    dir_row_t row;
    row.beat.task_id              = id;
    row.beat.task_priority        = prio;
    row.beat.last_pending         = last;
    row.typed                     = typed;
    row.result.head_changed       = hc;
    row.result.running_task       = run;
    row.result.insert_position    = pos;
    row.result.switch_needed      = sw;
    row.result.status             = st;
    dir_rows.push_back(row);
  endtask

  // Random batches: mostly descending pending lists, some out of order, some noise.
  task automatic run_phase(input int items);
    rqpm_in_t  beat;
    rqpm_out_t none;
    int        sent;
    int        batch_len;
    int        mode;
    int        prev_prio;
    int        j;
    none = '0;
    sent = 0;
    while (sent < items) begin
      batch_len = $urandom_range(4, 1);
      mode      = $urandom_range(99);
      prev_prio = $urandom_range(255, 1);
      for (j = 0; j < batch_len; j++) begin
        beat.task_id = 8'($urandom_range(255));
        if (mode < 70) begin
          prev_prio          = (j == 0) ? prev_prio : $urandom_range(prev_prio, 1);
          beat.task_priority = 8'(prev_prio);
          beat.last_pending  = (j == batch_len - 1);
        end else if (mode < 85) begin
          beat.task_priority = 8'($urandom_range(255, 1));
          beat.last_pending  = (j == batch_len - 1);
        end else begin
          beat.task_priority = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
          beat.last_pending  = 1'($urandom_range(1));
        end
        offer_task(beat, 1'b0, none);
        sent++;
      end
    end
  endtask

  // Hold the sender until every expected result beat has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sched_result_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off when the sender asks for one.
  always @(posedge clk_i) begin
    if (rx_hold_served != rx_hold_requests) begin
      rx_hold_served <= rx_hold_requests;
      rx_hold_left   <= RxHoldCycles;
      out_ready_i    <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    rqpm_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sched_result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected result beat: %p", out_data_o);
        end
      end else begin
        want = sched_result_q.pop_front();
        if (out_data_o.head_changed !== want.head_changed ||
            out_data_o.running_task !== want.running_task ||
            out_data_o.insert_position !== want.insert_position ||
            out_data_o.switch_needed !== want.switch_needed ||
            out_data_o.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("result mismatch: expected %p, got %p", want, out_data_o);
          end
        end
      end
    end
  end

  // Run limit.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAILURE");
    $finish;
  end

  // Main sequence: reset, directed table, three random phases, drain.
  initial begin
    int        k;
    cycle_count      = 0;
    mismatch_count   = 0;
    rx_hold_requests = 0;
    rx_hold_served   = 0;
    rx_hold_left     = 0;
    rx_idle_pct      = 0;
    tx_idle_pct      = 0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_data_i        = '0;
    for (k = 0; k < MaxTasks; k++) begin
      sched_prio[k] = '0;
      sched_id[k]   = '0;
    end
    sched_len    = 1;
    sched_switch = 1'b0;

    // Priority zero after reset, then the first real task taking the head.
    add_row(8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 5'd0, 1'b0, StPrioZero);
    add_row(8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 5'd0, 1'b0, StPrioZero);
    add_row(8'h01, 8'h01, 1'b1, 1'b1, 1'b1, 8'h01, 5'd0, 1'b1, StInserted);
    // Equal priority goes behind; a dropped last beat still reports the batch flag.
    add_row(8'h02, 8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    add_row(8'h03, 8'h10, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    add_row(8'h04, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    add_row(8'h05, 8'h08, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    // Out-of-order batch.
    add_row(8'h06, 8'h04, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    add_row(8'h07, 8'h20, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    add_row(8'h08, 8'h0C, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    // Descending batch with equal priorities, then the top priority.
    add_row(8'hAA, 8'h30, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    add_row(8'h55, 8'h30, 1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    add_row(8'h80, 8'h02, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);
    add_row(8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, StInserted);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      offer_task(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].result);
    end
    wait_drained();

    // Receiver idles more than sender first, then the other way round.
    tx_idle_pct = 31;
    rx_idle_pct <= 55;
    run_phase(PhaseItems);
    wait_drained();

    tx_idle_pct = 55;
    rx_idle_pct <= 31;
    run_phase(PhaseItems);
    wait_drained();

    // No idling; the receiver holds off for a long stretch at the start.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    rx_hold_requests <= rx_hold_requests + 1;
    run_phase(PhaseItems);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && sched_result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
